>>> src/voice_allocator_oldest_steal_core_assert.svh
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef VOICE_ALLOCATOR_OLDEST_STEAL_CORE_ASSERT_SVH
`define VOICE_ALLOCATOR_OLDEST_STEAL_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, sampled on clk, off during rst
`define VAOS_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("voice allocator: same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define VAOS_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("voice allocator: next-cycle check failed");

`else

`define VAOS_ASSERT_IMP(lbl, a, b)
`define VAOS_ASSERT_NXT(lbl, a, b)

`endif

`endif

>>> src/vaos_pkg.sv
// ----------------------------------------------------------------------------
// vaos_pkg
// Shared types, codes and helpers for the voice allocator.
// ----------------------------------------------------------------------------
package vaos_pkg;

  localparam int VOICES_DEFAULT = 6;

  // floor(p / 12) as (p * 43) >> 9, exact for 0..127
  localparam int OCTAVE_MUL   = 43;
  localparam int OCTAVE_SHIFT = 9;

  localparam logic [1:0] STAT_ASSIGNED = 2'd0;
  localparam logic [1:0] STAT_STOLEN   = 2'd1;
  localparam logic [1:0] STAT_RELEASED = 2'd2;
  localparam logic [1:0] STAT_IGNORED  = 2'd3;

  localparam logic OP_NOTE_ON  = 1'b0;
  localparam logic OP_NOTE_OFF = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [6:0] note_pitch;
  } cmd_t;

  typedef struct packed {
    logic [3:0] voice_index;
    logic [1:0] status;
    logic [6:0] out_pitch;
    logic [3:0] out_octave;
  } rsp_t;

  // what the shared compare unit tests this cycle
  typedef enum logic [1:0] {
    MODE_FREE,   // voice is inactive
    MODE_VOICE,  // voice is active and holds key
    MODE_QUEUE   // queue entry is live and equals key
  } scan_mode_t;

  typedef struct packed {
    logic push;   // append push_data at tail
    logic shift;  // drop entry at pos, close the gap
  } qctl_t;

  function automatic logic [3:0] octave_of(input logic [6:0] p);
    logic [12:0] prod;
    prod = 13'(p) * 13'(OCTAVE_MUL);
    return prod[12:OCTAVE_SHIFT];
  endfunction

endpackage

>>> src/vaos_match.sv
// ----------------------------------------------------------------------------
// vaos_match
// Shared compare unit: tests one voice or queue entry per cycle.
// ----------------------------------------------------------------------------
module vaos_match (
  input  vaos_pkg::scan_mode_t mode,
  input  logic                 voice_on,
  input  logic [6:0]           voice_note,
  input  logic [6:0]           queue_note,
  input  logic                 queue_live,
  input  logic [6:0]           key,
  output logic                 hit
);

  logic [6:0] operand;
  logic       eq;

  assign operand = (mode == vaos_pkg::MODE_QUEUE) ? queue_note : voice_note;
  assign eq      = (operand == key);

  always_comb begin
    case (mode)
      vaos_pkg::MODE_FREE:  hit = !voice_on;
      vaos_pkg::MODE_VOICE: hit = voice_on && eq;
      vaos_pkg::MODE_QUEUE: hit = queue_live && eq;
      default:              hit = 1'b0;
    endcase
  end

endmodule

>>> src/vaos_age_queue.sv
// ----------------------------------------------------------------------------
// vaos_age_queue
// Age-ordered pitch queue, oldest at the head, with remove-at and push.
// ----------------------------------------------------------------------------
module vaos_age_queue #(
  parameter int VOICES = vaos_pkg::VOICES_DEFAULT,
  localparam int IDXW  = $clog2(VOICES),
  localparam int CW    = $clog2(VOICES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  vaos_pkg::qctl_t   ctl,
  input  logic [IDXW-1:0]   pos,
  input  logic [6:0]        push_data,
  input  logic [IDXW-1:0]   rd_idx,
  output logic [6:0]        rd_data,
  output logic [6:0]        head,
  output logic [CW-1:0]     count
);

  logic [6:0] q [VOICES];

  assign rd_data = q[rd_idx];
  assign head    = q[0];

  // entries carry no reset; only those below count are ever used
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int j = 0; j < VOICES - 1; j++) begin
        if (IDXW'(j) >= pos) begin
          q[j] <= q[j+1];
        end
      end
    end else if (ctl.push && (count < CW'(VOICES))) begin
      q[count[IDXW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.shift && (count != '0)) begin
      count <= count - CW'(1);
    end else if (ctl.push && (count < CW'(VOICES))) begin
      count <= count + CW'(1);
    end
  end

endmodule

>>> src/voice_allocator_oldest_steal_core.sv
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal_core
// Polyphonic voice allocator with oldest-note stealing.
// ----------------------------------------------------------------------------
// An item (note on or note off with a 7-bit pitch) is taken when start is high
// and busy is low; busy then stays high until its single result has been
// shown. The result sits on rsp for exactly one cycle with done high and must
// be captured then, since the receiver has no way to hold it. One compare
// unit walks the voices or the age queue one entry per cycle, so an item's
// time from accept to done grows with the entry found. Note on scans for a
// free voice; a steal also scans for the voice to steal and drops the queue
// head; both push the new pitch. Note off scans voices, then the queue, and
// closes the gap. busy drops in the cycle that done is high, so the next
// item can be started right away. Note on takes the lowest free voice; with
// all busy it steals the lowest active voice holding the oldest queued pitch.
// Note off frees the lowest active voice with that pitch and drops that
// pitch's oldest queue entry; a note off for a pitch that is not sounding
// changes nothing and reports status ignored with voice_index 0. out_octave
// is pitch/12. Reset clears the active flags and the queue count at once;
// there is no clearing pass.
// ----------------------------------------------------------------------------
`include "voice_allocator_oldest_steal_core_assert.svh"

module voice_allocator_oldest_steal_core #(
  parameter int VOICES = vaos_pkg::VOICES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  vaos_pkg::cmd_t cmd,
  output logic           done,
  output vaos_pkg::rsp_t rsp
);

  localparam int IDXW = $clog2(VOICES);
  localparam int CW   = $clog2(VOICES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,    // look for lowest inactive voice
    ST_STEAL,   // look for lowest active voice holding the oldest pitch
    ST_OFF,     // look for lowest active voice holding the event pitch
    ST_QSCAN,   // look for the oldest queue entry of the released pitch
    ST_REMOVE,  // close the gap in the queue
    ST_PUSH,    // append the new pitch to the queue
    ST_DONE
  } state_t;

  state_t state;

  // item registers
  logic [6:0]      pitch;
  logic [6:0]      key;
  logic [IDXW-1:0] idx;
  logic [IDXW-1:0] pos;
  logic [IDXW-1:0] vidx;
  logic [1:0]      stat;

  // voice store: pitch has no reset, active flags do
  logic [6:0]        voice_pitch [VOICES];
  logic [VOICES-1:0] voice_active;

  // queue and compare unit hookup
  vaos_pkg::qctl_t      qctl;
  vaos_pkg::scan_mode_t mode;
  logic [6:0]           q_rd;
  logic [6:0]           q_head;
  logic [CW-1:0]        q_count;
  logic                 hit;
  logic                 last;

  assign busy = (state != ST_IDLE);
  assign last = (idx == IDXW'(VOICES - 1));

  always_comb begin
    case (state)
      ST_STEAL, ST_OFF: mode = vaos_pkg::MODE_VOICE;
      ST_QSCAN:         mode = vaos_pkg::MODE_QUEUE;
      default:          mode = vaos_pkg::MODE_FREE;
    endcase
    qctl.push  = (state == ST_PUSH);
    qctl.shift = (state == ST_REMOVE);
  end

  vaos_match u_match (
    .mode       (mode),
    .voice_on   (voice_active[idx]),
    .voice_note (voice_pitch[idx]),
    .queue_note (q_rd),
    .queue_live (CW'(idx) < q_count),
    .key        (key),
    .hit        (hit)
  );

  vaos_age_queue #(
    .VOICES (VOICES)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctl       (qctl),
    .pos       (pos),
    .push_data (pitch),
    .rd_idx    (idx),
    .rd_data   (q_rd),
    .head      (q_head),
    .count     (q_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      voice_active <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            pitch <= cmd.note_pitch;
            key   <= cmd.note_pitch;
            idx   <= '0;
            state <= (cmd.opcode == vaos_pkg::OP_NOTE_OFF) ? ST_OFF : ST_FREE;
          end
        end
        ST_FREE: begin
          if (hit) begin
            voice_pitch[idx]  <= pitch;
            voice_active[idx] <= 1'b1;
            vidx              <= idx;
            stat              <= vaos_pkg::STAT_ASSIGNED;
            state             <= ST_PUSH;
          end else if (last) begin
            if (q_count != '0) begin
              key   <= q_head;
              idx   <= '0;
              state <= ST_STEAL;
            end else begin
              vidx  <= '0;
              stat  <= vaos_pkg::STAT_IGNORED;
              state <= ST_DONE;
            end
          end else begin
            idx <= idx + IDXW'(1);
          end
        end
        ST_STEAL: begin
          if (hit) begin
            // voice stays active, only its pitch changes
            voice_pitch[idx] <= pitch;
            vidx             <= idx;
            stat             <= vaos_pkg::STAT_STOLEN;
            pos              <= '0;
            state            <= ST_REMOVE;
          end else if (last) begin
            vidx  <= '0;
            stat  <= vaos_pkg::STAT_IGNORED;
            state <= ST_DONE;
          end else begin
            idx <= idx + IDXW'(1);
          end
        end
        ST_OFF: begin
          if (hit) begin
            voice_active[idx] <= 1'b0;
            vidx              <= idx;
            stat              <= vaos_pkg::STAT_RELEASED;
            idx               <= '0;
            state             <= ST_QSCAN;
          end else if (last) begin
            vidx  <= '0;
            stat  <= vaos_pkg::STAT_IGNORED;
            state <= ST_DONE;
          end else begin
            idx <= idx + IDXW'(1);
          end
        end
        ST_QSCAN: begin
          if (hit) begin
            pos   <= idx;
            state <= ST_REMOVE;
          end else if (last) begin
            state <= ST_DONE;
          end else begin
            idx <= idx + IDXW'(1);
          end
        end
        ST_REMOVE: begin
          state <= (stat == vaos_pkg::STAT_STOLEN) ? ST_PUSH : ST_DONE;
        end
        ST_PUSH: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          rsp.voice_index <= 4'(vidx);
          rsp.status      <= stat;
          rsp.out_pitch   <= pitch;
          rsp.out_octave  <= vaos_pkg::octave_of(pitch);
          done            <= 1'b1;
          state           <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result strobe only as the sequencer returns to idle
  `VAOS_ASSERT_IMP(a_done_idle, done, !busy)
  // an accepted item always raises busy
  `VAOS_ASSERT_NXT(a_start_busy, start && !busy, busy)
  // between items the queue holds one entry per sounding voice
  `VAOS_ASSERT_IMP(a_count_sync, state == ST_IDLE, q_count == $countones(voice_active))
  // ignored events report voice zero
  `VAOS_ASSERT_IMP(a_ign_zero, done && (rsp.status == vaos_pkg::STAT_IGNORED), rsp.voice_index == 4'd0)

endmodule

>>> sim/tb_voice_allocator_oldest_steal_core.sv
// ----------------------------------------------------------------------------
// tb_voice_allocator_oldest_steal_core
// Self-checking bench for the oldest-steal voice allocator. A short table of
// note events runs first, then about a thousand random events that are mostly
// well-formed play/release sequences. A predictor keeps its own copy of the
// voice pool and the age queue, and every done result is compared field by
// field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_voice_allocator_oldest_steal_core;

  localparam int NUM_VOICES   = vaos_pkg::VOICES_DEFAULT;
  localparam int RANDOM_ITEMS = 1000;
  // drain at the end, longer than the slowest item
  localparam int DRAIN_CYCLES = 2 * NUM_VOICES + 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 32;
  localparam int EXP_DEPTH    = 16;
  localparam int DIRECTED_MAX = 32;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  vaos_pkg::cmd_t cmd;
  logic           done;
  vaos_pkg::rsp_t rsp;

  // expectation carried alongside the item: typed-in rows with a want bypass the predictor
  logic           item_has_want;
  vaos_pkg::rsp_t item_want;

  voice_allocator_oldest_steal_core #(
    .VOICES(NUM_VOICES)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: voice pool and age queue, oldest pitch at index 0
  // --------------------------------------------------------------------------
  logic [6:0] pool_pitch  [NUM_VOICES];
  logic       pool_active [NUM_VOICES];
  logic [6:0] age_fifo    [NUM_VOICES];
  int         age_len;

  // expected results, oldest at exp_rd
  vaos_pkg::rsp_t exp_fifo [EXP_DEPTH];
  int             exp_wr;
  int             exp_rd;
  int             exp_count;
  int             error_count;
  int             cycle_count;

  // drop the age entry at pos and close the gap
  function automatic void age_drop(input int pos);
    int i;
    for (i = pos; i + 1 < age_len; i++) age_fifo[i] = age_fifo[i + 1];
    age_len--;
  endfunction

  function automatic void age_append(input logic [6:0] p);
    if (age_len < NUM_VOICES) begin
      age_fifo[age_len] = p;
      age_len++;
    end
  endfunction

  // lowest active voice holding pitch p, -1 if none
  function automatic int find_sounding(input logic [6:0] p);
    int i;
    int v;
    v = -1;
    for (i = NUM_VOICES - 1; i >= 0; i--) begin
      if (pool_active[i] && pool_pitch[i] == p) v = i;
    end
    return v;
  endfunction

  // applies one note event to the pool and returns the result it causes
  function automatic vaos_pkg::rsp_t allocate_voice(input vaos_pkg::cmd_t c);
    vaos_pkg::rsp_t r;
    int             v;
    int             i;
    bit             found;
    r.voice_index = 4'd0;
    r.status      = vaos_pkg::STAT_IGNORED;
    r.out_pitch   = c.note_pitch;
    r.out_octave  = 4'(c.note_pitch / 7'd12);
    v = -1;
    if (c.opcode == vaos_pkg::OP_NOTE_ON) begin
      for (i = NUM_VOICES - 1; i >= 0; i--) begin
        if (!pool_active[i]) v = i;
      end
      if (v >= 0) begin
        pool_pitch[v]  = c.note_pitch;
        pool_active[v] = 1'b1;
        age_append(c.note_pitch);
        r.status      = vaos_pkg::STAT_ASSIGNED;
        r.voice_index = 4'(v);
      end else if (age_len > 0) begin
        // all voices busy: take over the voice of the oldest queued pitch
        v = find_sounding(age_fifo[0]);
        if (v >= 0) begin
          age_drop(0);
          pool_pitch[v]  = c.note_pitch;
          pool_active[v] = 1'b1;
          age_append(c.note_pitch);
          r.status      = vaos_pkg::STAT_STOLEN;
          r.voice_index = 4'(v);
        end
      end
    end else begin
      v = find_sounding(c.note_pitch);
      if (v >= 0) begin
        pool_active[v] = 1'b0;
        found = 1'b0;
        for (i = 0; i < age_len; i++) begin
          if (!found && age_fifo[i] == c.note_pitch) begin
            age_drop(i);
            found = 1'b1;
          end
        end
        r.status      = vaos_pkg::STAT_RELEASED;
        r.voice_index = 4'(v);
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: results are checked first, then an item accepted on the same
  // edge (busy drops in the done cycle) is run through the predictor.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    vaos_pkg::rsp_t want;
    vaos_pkg::rsp_t got;
    if (!rst) begin
      if (done) begin
        if (exp_count == 0) begin
          $error("result with nothing expected: voice_index %0d status %0d pitch %0d",
                 rsp.voice_index, rsp.status, rsp.out_pitch);
          error_count++;
        end else begin
          want      = exp_fifo[exp_rd];
          exp_rd    = (exp_rd + 1) % EXP_DEPTH;
          exp_count = exp_count - 1;
          if (rsp.voice_index !== want.voice_index) begin
            $error("voice_index: expected %0d, got %0d", want.voice_index, rsp.voice_index);
            error_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            error_count++;
          end
          if (rsp.out_pitch !== want.out_pitch) begin
            $error("out_pitch: expected %0d, got %0d", want.out_pitch, rsp.out_pitch);
            error_count++;
          end
          if (rsp.out_octave !== want.out_octave) begin
            $error("out_octave: expected %0d, got %0d", want.out_octave, rsp.out_octave);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        // predictor runs on every item so its pool tracks typed rows too
        got = allocate_voice(cmd);
        if (exp_count == EXP_DEPTH) begin
          $error("expected-result store overflow");
          error_count++;
        end else begin
          exp_fifo[exp_wr] = item_has_want ? item_want : got;
          exp_wr           = (exp_wr + 1) % EXP_DEPTH;
          exp_count        = exp_count + 1;
        end
      end
    end
  end

  // run guard: a hung handshake ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  typedef struct {
    vaos_pkg::cmd_t c;
    bit             has_want;
    vaos_pkg::rsp_t want;
  } stim_row_t;

  stim_row_t directed_rows [DIRECTED_MAX];
  int        row_count;

  task automatic add_row(input logic op, input logic [6:0] p, input bit has_want,
                         input logic [3:0] vi, input logic [1:0] st,
                         input logic [3:0] oct);
    stim_row_t row;
    row.c.opcode          = op;
    row.c.note_pitch      = p;
    row.has_want          = has_want;
    row.want.voice_index  = vi;
    row.want.status       = st;
    row.want.out_pitch    = p;
    row.want.out_octave   = oct;
    if (row_count < DIRECTED_MAX) begin
      directed_rows[row_count] = row;
      row_count++;
    end
  endtask

  // entered and left at a falling edge; start stays high from one item to
  // the next unless an idle gap is drawn, so it is assigned once per step
  task automatic send_item(input vaos_pkg::cmd_t c, input bit has_want,
                           input vaos_pkg::rsp_t want, input bit may_idle);
    if (may_idle) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start         <= 1'b1;
    cmd           <= c;
    item_has_want <= has_want;
    item_want     <= want;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // mostly well-formed play/release traffic, some stray note-offs
  function automatic vaos_pkg::cmd_t random_note_event();
    vaos_pkg::cmd_t c;
    int             sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      c.opcode = vaos_pkg::OP_NOTE_ON;
      // a narrow band makes repeated pitches common
      if ($urandom_range(0, 99) < 40) c.note_pitch = 7'(60 + $urandom_range(0, 3));
      else                            c.note_pitch = 7'($urandom_range(0, 127));
    end else if (sel < 85 && age_len > 0) begin
      c.opcode     = vaos_pkg::OP_NOTE_OFF;
      c.note_pitch = age_fifo[$urandom_range(0, age_len - 1)];
    end else begin
      c.opcode     = vaos_pkg::OP_NOTE_OFF;
      c.note_pitch = 7'($urandom_range(0, 127));
    end
    return c;
  endfunction

  initial begin
    vaos_pkg::rsp_t no_want;
    vaos_pkg::cmd_t c;
    int             n;
    clk           = 1'b0;
    rst           = 1'b1;
    start         = 1'b0;
    cmd           = '0;
    item_has_want = 1'b0;
    item_want     = '0;
    no_want       = '0;
    error_count   = 0;
    cycle_count   = 0;
    exp_wr        = 0;
    exp_rd        = 0;
    exp_count     = 0;
    row_count     = 0;
    age_len       = 0;
    for (n = 0; n < NUM_VOICES; n++) begin
      pool_active[n] = 1'b0;
      pool_pitch[n]  = '0;
      age_fifo[n]    = '0;
    end

    // typed rows: empty pool after reset, pitch extremes, ignored note-offs
    add_row(vaos_pkg::OP_NOTE_OFF, 7'd0,   1'b1, 4'd0, vaos_pkg::STAT_IGNORED,  4'd0);
    add_row(vaos_pkg::OP_NOTE_OFF, 7'd127, 1'b1, 4'd0, vaos_pkg::STAT_IGNORED,  4'd10);
    add_row(vaos_pkg::OP_NOTE_ON,  7'd0,   1'b1, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_ON,  7'd127, 1'b1, 4'd1, vaos_pkg::STAT_ASSIGNED, 4'd10);
    // fill the pool, with a repeated pitch
    add_row(vaos_pkg::OP_NOTE_ON,  7'd60,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_ON,  7'd60,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_ON,  7'd72,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_ON,  7'd11,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    // full pool: steals walk the age queue, repeated pitch takes lowest voice
    add_row(vaos_pkg::OP_NOTE_ON,  7'd12,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_ON,  7'd13,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_ON,  7'd85,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    // releases, then a second release of a pitch that is gone
    add_row(vaos_pkg::OP_NOTE_OFF, 7'd60,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_OFF, 7'd60,  1'b1, 4'd0, vaos_pkg::STAT_IGNORED,  4'd5);
    add_row(vaos_pkg::OP_NOTE_ON,  7'd24,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    // stolen pitch no longer sounds
    add_row(vaos_pkg::OP_NOTE_OFF, 7'd127, 1'b1, 4'd0, vaos_pkg::STAT_IGNORED,  4'd10);
    add_row(vaos_pkg::OP_NOTE_OFF, 7'd11,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_OFF, 7'd12,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_ON,  7'd1,   1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_ON,  7'd2,   1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_ON,  7'd127, 1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    // drain the pool back to empty
    add_row(vaos_pkg::OP_NOTE_OFF, 7'd127, 1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_OFF, 7'd13,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_OFF, 7'd85,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_OFF, 7'd24,  1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_OFF, 7'd1,   1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);
    add_row(vaos_pkg::OP_NOTE_OFF, 7'd2,   1'b0, 4'd0, vaos_pkg::STAT_ASSIGNED, 4'd0);

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (n = 0; n < row_count; n++) begin
      send_item(directed_rows[n].c, directed_rows[n].has_want,
                directed_rows[n].want, 1'b1);
    end

    // random part; a stretch in the middle runs back to back with no gaps
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      c = random_note_event();
      send_item(c, 1'b0, no_want, !(n >= 300 && n < 550));
    end
    start <= 1'b0;

    while (exp_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
